@@ design/two_class_priority_queue_defines.svh @@
// Assertion helpers shared by the checker.
// Both expect clk and rst_n in scope; checks are off while reset is held.
`ifndef TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define TPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

    localparam int DATA_W = 16;
    localparam int OCC_W  = 5;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_TAIL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd2;

    localparam logic signed [DATA_W-1:0] THR_RESET = 16'sd60;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } cell_op_t;

    // Broadcast to every cell.
    typedef struct packed {
        cell_op_t op;
        logic     prio_ins;
    } tpq_ctrl_t;

    // Passed from each cell to its right-hand neighbor.
    typedef struct packed {
        logic below_seen;
        logic at_after;
    } tpq_link_t;

endpackage

`default_nettype wire

@@ design/tpq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpq_cell
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 16,
    parameter int IDX         = 0,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int CMP_W      = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W
)
(
    input  wire logic                    clk,
    input  wire tpq_ctrl_t               ctrl,
    input  wire logic [CNT_W-1:0]        count,
    input  wire logic [VALUE_WIDTH-1:0]  ins_value,
    input  wire logic signed [CMP_W-1:0] thr,
    input  wire logic [VALUE_WIDTH-1:0]  left_entry,
    input  wire logic [VALUE_WIDTH-1:0]  right_entry,
    input  wire tpq_link_t               link_in,
    output tpq_link_t                    link_out,
    output logic [VALUE_WIDTH-1:0]       entry
);

    logic [VALUE_WIDTH-1:0]  entry_reg;
    logic [VALUE_WIDTH-1:0]  entry_next;
    logic                    occupied;
    logic signed [CMP_W-1:0] entry_s;
    logic                    below;
    logic                    below_seen;
    logic                    at_after;

    assign occupied   = CNT_W'(IDX) < count;
    assign entry_s    = CMP_W'($signed(entry_reg));
    assign below      = occupied && (entry_s < thr);
    assign below_seen = link_in.below_seen | below;
    // Insert point is the first free slot, or the first low entry on a priority insert.
    assign at_after   = !occupied | (ctrl.prio_ins & below_seen);

    assign link_out.below_seen = below_seen;
    assign link_out.at_after   = at_after;
    assign entry               = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (link_in.at_after)
                begin
                    entry_next = left_entry;
                end
                else if (at_after)
                begin
                    entry_next = ins_value;
                end
            end
            CELL_POP:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ design/two_class_priority_queue.sv @@
// Latency: a result shows the cycle after acceptance unless held in the skid entry.
// Throughput: one operation per cycle unless in_stall; every cell compares against
// the threshold and shifts in the same cycle; a two-deep output buffer takes stalls.
// Reset: entry count and output buffer valid flags cleared, threshold set to 60.
// Entry cells are not cleared; only the occupied ones are ever read.
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_queue
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic signed [DATA_W-1:0] cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      head_value,
    output logic [1:0]                    status,
    output logic [OCC_W-1:0]              occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [DATA_W-1:0] thr_reg;

    logic                    out_valid_reg;
    logic [DATA_W-1:0]       out_head_reg;
    status_t                 out_status_reg;
    logic [OCC_W-1:0]        out_occ_reg;
    logic                    skid_valid_reg;
    logic [DATA_W-1:0]       skid_head_reg;
    status_t                 skid_status_reg;
    logic [OCC_W-1:0]        skid_occ_reg;

    logic                    accept;
    logic                    out_take;
    logic                    full;
    logic                    empty;
    logic [VALUE_WIDTH-1:0]  ins_value;
    logic signed [CMP_W-1:0] thr_ext;
    logic signed [CMP_W-1:0] ins_ext;
    logic                    val_hi;
    tpq_ctrl_t               ctrl;
    logic [DATA_W-1:0]       res_head;
    status_t                 res_status;
    logic [OCC_W-1:0]        res_occ;

    logic [VALUE_WIDTH-1:0]  cell_entry [QUEUE_DEPTH];
    tpq_link_t               link [QUEUE_DEPTH+1];

    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign ins_value = VALUE_WIDTH'($unsigned(value));
    assign thr_ext   = CMP_W'(thr_reg);
    assign ins_ext   = CMP_W'($signed(ins_value));
    assign val_hi    = ins_ext >= thr_ext;

    always_comb
    begin
        ctrl.op       = CELL_HOLD;
        ctrl.prio_ins = 1'b0;
        res_head      = '0;
        res_status    = ST_DONE;
        count_next    = count_reg;
        if (accept)
        begin
            case (mode) inside
                MODE_TAIL, MODE_PRIO:
                begin
                    if (full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.op       = CELL_INSERT;
                        ctrl.prio_ins = (mode == MODE_PRIO) && val_hi;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                MODE_DEQ:
                begin
                    if (empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.op    = CELL_POP;
                        res_head   = DATA_W'(cell_entry[0]);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    ctrl.op = CELL_HOLD;
                end
            endcase
        end
    end

    assign res_occ = OCC_W'(count_next);

    assign link[0].below_seen = 1'b0;
    assign link[0].at_after   = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_w;
        logic [VALUE_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_w = cell_entry[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_entry[i+1];
        end

        tpq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .ins_value   (ins_value),
            .thr         (thr_ext),
            .left_entry  (left_w),
            .right_entry (right_w),
            .link_in     (link[i]),
            .link_out    (link[i+1]),
            .entry       (cell_entry[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            thr_reg   <= THR_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // Output buffer: main register plus one skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_head_reg   <= skid_head_reg;
                out_status_reg <= skid_status_reg;
                out_occ_reg    <= skid_occ_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_head_reg   <= res_head;
                skid_status_reg <= res_status;
                skid_occ_reg    <= res_occ;
            end
            else
            begin
                out_head_reg   <= res_head;
                out_status_reg <= res_status;
                out_occ_reg    <= res_occ;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign head_value = $signed(out_head_reg);
    assign status     = out_status_reg;
    assign occupancy  = out_occ_reg;

endmodule

`default_nettype wire

@@ design/tpq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "two_class_priority_queue_defines.svh"

module tpq_checker
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_stall,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic signed [DATA_W-1:0] head_value,
    input  wire logic [1:0]               status,
    input  wire logic [OCC_W-1:0]         occupancy
);

    `TPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `TPQ_ASSERT_NOW(a_stall_buffered, in_stall, out_valid, "input stalled with no result pending")
    `TPQ_ASSERT_NOW(a_empty_result, out_valid && (status == ST_EMPTY), (occupancy == '0) && (head_value == '0), "empty status with entries or data")
    `TPQ_ASSERT_NOW(a_full_result, out_valid && (status == ST_FULL), (occupancy == OCC_W'(QUEUE_DEPTH)) && (head_value == '0), "full status with wrong occupancy or data")

endmodule

bind two_class_priority_queue tpq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tpq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head_value (head_value),
    .status     (status),
    .occupancy  (occupancy)
);

`default_nettype wire

@@ verif/two_class_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module two_class_priority_queue_tb;
    import tpq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_COUNT = 7;
    localparam int QUIET_AFTER = 1250;
    localparam int STALL_LIMIT = 1000;
    localparam int DIRECTED_ROWS = 23;

    typedef struct packed {
        logic signed [DATA_W-1:0] head;
        status_t                  status;
        logic [OCC_W-1:0]         occ;
    } queue_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]        op;
        logic signed [DATA_W-1:0] v;
        logic                     typed;
        queue_result_t            want;
    } directed_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic signed [DATA_W-1:0] cfg_wr_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] head_value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;

    // Predictor state: the queue contents and the threshold it compares against.
    logic signed [DATA_W-1:0] model_entries[$];
    logic signed [DATA_W-1:0] model_threshold;
    queue_result_t            pending_results[$];
    queue_result_t            oldest_result;

    bit quiet;
    bit sender_calm;
    bit sink_calm;
    int stall_left;
    int idle_cycles;
    int fail_count;
    int items_sent;
    int results_seen;
    int full_rejects;
    int empty_dequeues;
    int prio_inserts;

    // Typed rows hold results readable straight from the queue's rules.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_DEQ,    16'sd0,      1'b1, '{16'sd0, ST_EMPTY, 5'd0}},
        '{MODE_UNUSED, 16'sh7FFF,   1'b1, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_TAIL,   16'sd10,     1'b1, '{16'sd0, ST_DONE,  5'd1}},
        '{MODE_PRIO,   16'sd60,     1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_PRIO,   16'sd59,     1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_PRIO,   16'sh7FFF,   1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_TAIL,   16'sh8000,   1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_PRIO,   16'sh8000,   1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_TAIL,   -16'sd1,     1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_PRIO,   16'sh5555,   1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_TAIL,   16'shAAAA,   1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_PRIO,   16'sd61,     1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_TAIL,   16'sd0,      1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_PRIO,   16'sd100,    1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_TAIL,   16'sd1,      1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_PRIO,   -16'sd100,   1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_TAIL,   16'sd7,      1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_PRIO,   16'sd200,    1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_TAIL,   16'sd5,      1'b1, '{16'sd0, ST_FULL,  5'd16}},
        '{MODE_PRIO,   16'sh7FFF,   1'b1, '{16'sd0, ST_FULL,  5'd16}},
        '{MODE_DEQ,    16'sd0,      1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_DEQ,    16'shFFFF,   1'b0, '{16'sd0, ST_DONE,  5'd0}},
        '{MODE_UNUSED, -16'sd1,     1'b1, '{16'sd0, ST_DONE,  5'd14}}
    };

    two_class_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .VALUE_WIDTH(DATA_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .head_value(head_value),
        .status(status),
        .occupancy(occupancy)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply one operation to the predicted queue and return its result.
    function automatic queue_result_t apply_queue_op(input logic [MODE_W-1:0] op,
                                                     input logic signed [DATA_W-1:0] v);
        queue_result_t r;
        int pos;
        int i;
        r.head = '0;
        r.status = ST_DONE;
        if (op == MODE_TAIL || op == MODE_PRIO) begin
            if (model_entries.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                pos = model_entries.size();
                // A priority value goes ahead of the first entry below the threshold.
                if (op == MODE_PRIO && v >= model_threshold) begin
                    for (i = 0; i < model_entries.size(); i++) begin
                        if (pos == model_entries.size() && model_entries[i] < model_threshold)
                            pos = i;
                    end
                end
                model_entries.insert(pos, v);
            end
        end
        else if (op == MODE_DEQ) begin
            if (model_entries.size() == 0)
                r.status = ST_EMPTY;
            else
                r.head = model_entries.pop_front();
        end
        r.occ = OCC_W'(model_entries.size());
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = model_threshold + DATA_W'($urandom_range(0, 6)) - 16'sd3;
            3: begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh8000;
                    1: v = 16'sh7FFF;
                    2: v = 16'sd0;
                    default: v = -16'sd1;
                endcase
            end
            default: v = DATA_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input int enq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return MODE_UNUSED;
        if (r < 3 + enq_pct)
            return $urandom_range(0, 1) ? MODE_PRIO : MODE_TAIL;
        return MODE_DEQ;
    endfunction

    // Present one transaction, hold it until accepted, then log what it should produce.
    task automatic send_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] v,
                           input logic typed, input queue_result_t want);
        queue_result_t predicted;
        if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= op;
        value <= v;
        do @(posedge clk); while (in_stall);
        predicted = apply_queue_op(op, v);
        if (predicted.status == ST_FULL)
            full_rejects++;
        if (predicted.status == ST_EMPTY)
            empty_dequeues++;
        if (op == MODE_PRIO && v >= model_threshold)
            prio_inserts++;
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_all_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write the threshold only once the queue has gone quiet.
    task automatic write_threshold(input logic signed [DATA_W-1:0] thr);
        in_valid <= 1'b0;
        wait_all_results();
        repeat (3) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_threshold = thr;
    endtask

    initial begin
        int row;
        int phase;
        int seg_left;
        int enq_pct;
        int sent_in_phase;
        logic signed [DATA_W-1:0] thr;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        mode = MODE_TAIL;
        value = '0;
        quiet = 1'b0;
        sender_calm = 1'b0;
        sink_calm = 1'b0;
        model_threshold = THR_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
            send_op(directed_rows[row].op, directed_rows[row].v,
                    directed_rows[row].typed, directed_rows[row].want);

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                1: thr = 16'sh8000;
                2: thr = 16'sh7FFF;
                3: thr = 16'sd0;
                4: thr = -16'sd1;
                5: thr = DATA_W'($urandom);
                6: thr = THR_RESET;
                default: thr = model_threshold;
            endcase
            // The first phase runs on the threshold left by reset.
            if (phase != 0)
                write_threshold(thr);
            seg_left = 0;
            enq_pct = 47;
            for (sent_in_phase = 0; sent_in_phase < RANDOM_ITEMS / PHASE_COUNT;
                 sent_in_phase++) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 60);
                    case ($urandom_range(0, 2))
                        0: enq_pct = 77;
                        1: enq_pct = 17;
                        default: enq_pct = 47;
                    endcase
                    sender_calm <= ($urandom_range(0, 3) == 0);
                    sink_calm <= ($urandom_range(0, 3) == 0);
                end
                seg_left--;
                if (items_sent >= QUIET_AFTER)
                    quiet <= 1'b1;
                send_op(pick_mode(enq_pct), pick_value(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        wait_all_results();
        repeat (5) @(posedge clk);
        $display("Ran %0d transactions over %0d threshold settings, %0d results checked.",
                 items_sent, PHASE_COUNT, results_seen);
        $display("Saw %0d priority inserts, %0d full rejects, %0d empty dequeues.",
                 prio_inserts, full_rejects, empty_dequeues);
        if (fail_count == 0)
            $display("two_class_priority_queue verification clean");
        else
            $display("two_class_priority_queue verification failed");
        $finish;
    end

    // Sink backpressure in random bursts.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && !sink_calm && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: head_value %0d status %0d occupancy %0d",
                       head_value, status, occupancy);
                fail_count++;
            end
            else begin
                oldest_result = pending_results.pop_front();
                if (head_value !== oldest_result.head) begin
                    $error("head_value mismatch: expected %0d, actual %0d",
                           oldest_result.head, head_value);
                    fail_count++;
                end
                if (status !== oldest_result.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           oldest_result.status, status);
                    fail_count++;
                end
                if (occupancy !== oldest_result.occ) begin
                    $error("occupancy mismatch: expected %0d, actual %0d",
                           oldest_result.occ, occupancy);
                    fail_count++;
                end
            end
        end
    end

    // Abort if neither side moves a transaction for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timed out with %0d results outstanding.", pending_results.size());
            $display("two_class_priority_queue verification failed");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ two_class_priority_queue.f @@
+incdir+design
design/tpq_pkg.sv
design/tpq_cell.sv
design/two_class_priority_queue.sv
design/tpq_checker.sv
verif/two_class_priority_queue_tb.sv
